>>> hdl/xee_pkg.sv
// Package for the XML entity escape/unescape block.
// Holds byte and count types, the entity tables and register codes; no dependencies.
`default_nettype none

package xee_pkg;

    localparam int NENT     = 4;
    localparam int HOLD_MAX = 5;
    localparam int OUT_MAX  = 6;
    localparam int ADDR_W   = 3;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] cnt_t;
    typedef logic [1:0] ent_idx_t;

    typedef enum logic
    {
        DIR_ESCAPE   = 1'b0,
        DIR_UNESCAPE = 1'b1
    } dir_t;

    // Register index, taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;

    localparam byte_t CHAR_AMP = 8'h26;

    localparam byte_t ENT_TEXT [NENT][OUT_MAX] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}   // &gt;
    };

    localparam cnt_t ENT_LEN [NENT] = '{3'd5, 3'd6, 3'd4, 3'd4};

    localparam byte_t ENT_CHAR [NENT] = '{8'h26, 8'h22, 8'h3c, 8'h3e};

endpackage

`default_nettype wire

>>> hdl/xee_in_if.sv
// Input text channel: valid/ready handshake carrying one text byte per item.
// No dependencies.
`default_nettype none

interface xee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, output byte_in, output end_of_text, input ready);
    modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> hdl/xee_out_if.sv
// Output text channel: valid/ready handshake carrying one converted byte per item.
// No dependencies.
`default_nettype none

interface xee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_of_run;
    logic       text_done;

    modport source (output valid, output byte_out, output last_of_run, output text_done,
                    input ready);
    modport sink   (input valid, input byte_out, input last_of_run, input text_done,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/xml_entity_escape_unescape.sv
// Top level of the XML entity escape/unescape block.
// Depends on xee_pkg, xee_in_if and xee_out_if.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+-----------------------------------------
//  txt_in    | in  | valid/ready    | byte_in[7:0], end_of_text
//  txt_out   | out | valid/ready    | byte_out[7:0], last_of_run, text_done
//  apb       | in  | psel/penable   | paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// An input item is converted in the cycle it is accepted; its zero to six result
// bytes are loaded into a six-byte shift buffer and leave one per cycle while txt_out is ready.
// The single-byte output port drains the shift buffer, so a new item waits for
// the result bytes of the previous item to leave.
// The next item is accepted in the cycle the last buffered byte is taken.
// Reset clears direction (escape), the held count and the buffer count; held bytes are
// left unset and only ever read after being written.
// A stall on txt_out holds the buffer and blocks txt_in until the buffer drains.
`default_nettype none

module xml_entity_escape_unescape
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    xee_in_if.sink                         txt_in,
    xee_out_if.source                      txt_out,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [xee_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);
    import xee_pkg::*;

    // Configuration and partial-entity state
    dir_t   dir_reg,         dir_next;
    byte_t  held_reg [HOLD_MAX];
    byte_t  held_next [HOLD_MAX];
    cnt_t   held_count_reg,  held_count_next;

    // Result shift buffer
    byte_t  sbuf_reg [OUT_MAX];
    byte_t  sbuf_next [OUT_MAX];
    cnt_t   rem_reg,         rem_next;
    logic   seot_reg,        seot_next;

    // Datapath results
    byte_t  seq [OUT_MAX];
    byte_t  res_buf [OUT_MAX];
    cnt_t   res_cnt;
    byte_t  held_calc [HOLD_MAX];
    cnt_t   held_count_calc;
    cnt_t   m;
    logic   esc_hit;
    ent_idx_t esc_k;
    logic   any_done;
    logic   any_prefix;
    byte_t  done_char;
    logic   ent_match [NENT];

    logic   in_acc;
    logic   out_take;
    logic   cfg_wr;
    byte_t  b;
    logic   eot;

    assign b   = txt_in.byte_in;
    assign eot = txt_in.end_of_text;

    // Handshakes
    assign txt_in.ready  = (rem_reg == '0) || (txt_out.ready && (rem_reg == cnt_t'(1)));
    assign in_acc        = txt_in.valid && txt_in.ready;
    assign txt_out.valid = (rem_reg != '0);
    assign out_take      = txt_out.valid && txt_out.ready;

    assign txt_out.byte_out    = sbuf_reg[0];
    assign txt_out.last_of_run = (rem_reg == cnt_t'(1));
    assign txt_out.text_done   = (rem_reg == cnt_t'(1)) && seot_reg;

    // APB: single register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_reg} : 32'b0;

    // Candidate sequence: held bytes followed by the new byte
    always_comb
    begin
        for (int i = 0; i < HOLD_MAX; i++)
        begin
            seq[i] = (cnt_t'(i) < held_count_reg) ? held_reg[i] : b;
        end
        seq[HOLD_MAX] = b;
    end

    assign m = held_count_reg + cnt_t'(1);

    // Compare the candidate against every entity prefix of length m
    always_comb
    begin
        any_done   = 1'b0;
        any_prefix = 1'b0;
        done_char  = ENT_CHAR[0];
        for (int k = 0; k < NENT; k++)
        begin
            ent_match[k] = (m <= ENT_LEN[k]);
            for (int i = 0; i < OUT_MAX; i++)
            begin
                if ((cnt_t'(i) < m) && (seq[i] != ENT_TEXT[k][i]))
                begin
                    ent_match[k] = 1'b0;
                end
            end
            if (ent_match[k] && (m == ENT_LEN[k]))
            begin
                any_done  = 1'b1;
                done_char = ENT_CHAR[k];
            end
            if (ent_match[k] && (m < ENT_LEN[k]))
            begin
                any_prefix = 1'b1;
            end
        end
    end

    // Escape lookup
    always_comb
    begin
        esc_hit = 1'b0;
        esc_k   = '0;
        for (int k = 0; k < NENT; k++)
        begin
            if (b == ENT_CHAR[k])
            begin
                esc_hit = 1'b1;
                esc_k   = ent_idx_t'(k);
            end
        end
    end

    // Conversion of one item: results into res_buf/res_cnt, new hold state
    always_comb
    begin
        res_buf         = seq;
        res_cnt         = '0;
        held_calc       = held_reg;
        held_count_calc = held_count_reg;

        if (dir_reg == DIR_ESCAPE)
        begin
            if (esc_hit)
            begin
                res_buf = ENT_TEXT[esc_k];
                res_cnt = ENT_LEN[esc_k];
            end
            else
            begin
                res_buf[0] = b;
                res_cnt    = cnt_t'(1);
            end
        end
        else if (held_count_reg == '0)
        begin
            // Open a new entity on '&', unless the text ends here
            if ((b == CHAR_AMP) && !eot)
            begin
                held_calc[0]    = b;
                held_count_calc = cnt_t'(1);
            end
            else
            begin
                res_buf[0] = b;
                res_cnt    = cnt_t'(1);
            end
        end
        else if (any_done)
        begin
            res_buf[0]      = done_char;
            res_cnt         = cnt_t'(1);
            held_count_calc = '0;
        end
        else if (any_prefix && (m <= cnt_t'(HOLD_MAX)))
        begin
            if (eot)
            begin
                // Flush the unfinished entity as plain text
                res_cnt         = m;
                held_count_calc = '0;
            end
            else
            begin
                held_calc[held_count_reg] = b;
                held_count_calc           = m;
            end
        end
        else
        begin
            // Mismatch: drop the held bytes out unchanged, then rescan the new byte
            if ((b == CHAR_AMP) && !eot)
            begin
                res_cnt         = held_count_reg;
                held_calc[0]    = b;
                held_count_calc = cnt_t'(1);
            end
            else
            begin
                res_cnt         = m;
                held_count_calc = '0;
            end
        end
    end

    // Next-state selection
    always_comb
    begin
        dir_next        = dir_reg;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        sbuf_next       = sbuf_reg;
        rem_next        = rem_reg;
        seot_next       = seot_reg;

        if (in_acc)
        begin
            held_next       = held_calc;
            held_count_next = held_count_calc;
            sbuf_next       = res_buf;
            rem_next        = res_cnt;
            seot_next       = eot;
        end
        else if (out_take)
        begin
            // Advance the buffer by one byte
            for (int i = 0; i < OUT_MAX - 1; i++)
            begin
                sbuf_next[i] = sbuf_reg[i + 1];
            end
            rem_next = rem_reg - cnt_t'(1);
        end

        if (cfg_wr)
        begin
            dir_next        = dir_t'(pwdata[0]);
            held_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg        <= DIR_ESCAPE;
            held_count_reg <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            dir_reg        <= dir_next;
            held_count_reg <= held_count_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        sbuf_reg <= sbuf_next;
        seot_reg <= seot_next;
    end

    // Checks
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= cnt_t'(HOLD_MAX))
        else $error("held count above hold depth");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= cnt_t'(OUT_MAX))
        else $error("result buffer count above depth");

    a_escape_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg == DIR_ESCAPE) |-> (held_count_reg == '0))
        else $error("bytes held in escape mode");

    a_hold_starts_amp: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != '0) |-> (held_reg[0] == CHAR_AMP))
        else $error("held entity does not start with ampersand");

    a_ready_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        txt_in.ready |-> (rem_reg <= cnt_t'(1)))
        else $error("input ready while buffer still holds several bytes");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for xml_entity_escape_unescape: escape and unescape of a byte stream.
// Depends on xee_pkg, xee_in_if, xee_out_if and the block's top level; needs no files or arguments.
module tb;
    import xee_pkg::*;

    // Byte address of each configuration register (4 bytes per register)
    localparam logic [ADDR_W-1:0] ADDR_DIRECTION = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_SPARE     = 3'd4;

    localparam int N_ENTITIES = 4;
    localparam int HOLD_DEPTH = 5;
    localparam int MAX_SHOWN  = 10;
    localparam int SETTLE     = 8;

    // Entity spellings and the characters they stand for
    localparam byte_t ENTITY_TEXT [N_ENTITIES][6] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00}
    };
    localparam int    ENTITY_LEN  [N_ENTITIES] = '{5, 6, 4, 4};
    localparam byte_t ENTITY_CHAR [N_ENTITIES] = '{"&", "\"", "<", ">"};

    typedef struct packed
    {
        byte_t data;
        logic  last;
        logic  done;
    } txt_res_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    xee_in_if  txt_in_if ();
    xee_out_if txt_out_if ();

    xml_entity_escape_unescape dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .txt_in  (txt_in_if),
        .txt_out (txt_out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: mirrors the block's direction and its partial entity
    dir_t       cur_dir = DIR_ESCAPE;
    byte_t      held_text [HOLD_DEPTH];
    int         held_len = 0;

    // Result bytes still owed by the block, oldest first
    txt_res_t   expected_text [$];

    int         error_count = 0;
    int         burst_left = 0;
    logic [7:0] stall_phase = 8'd0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Count a failure; print only the first few
    task automatic flag_error(string what);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // Work out the result bytes one accepted input byte causes, and queue them
    function automatic void convert_item(byte_t b, logic eot);
        txt_res_t run [$];
        txt_res_t r;
        byte_t    seq [HOLD_DEPTH + 1];
        int       hit;
        int       partial;
        int       m;
        bit       same;

        r.last = 1'b0;
        r.done = 1'b0;
        if (cur_dir == DIR_ESCAPE)
        begin
            hit = -1;
            for (int k = 0; k < N_ENTITIES; k++)
                if (b == ENTITY_CHAR[k])
                    hit = k;
            if (hit >= 0)
            begin
                for (int i = 0; i < ENTITY_LEN[hit]; i++)
                begin
                    r.data = ENTITY_TEXT[hit][i];
                    run.push_back(r);
                end
            end
            else
            begin
                r.data = b;
                run.push_back(r);
            end
        end
        else
        begin
            if (held_len == 0)
            begin
                if (b == "&")
                begin
                    held_text[0] = b;
                    held_len = 1;
                end
                else
                begin
                    r.data = b;
                    run.push_back(r);
                end
            end
            else
            begin
                for (int i = 0; i < held_len; i++)
                    seq[i] = held_text[i];
                seq[held_len] = b;
                m = held_len + 1;
                hit = -1;
                partial = 0;
                for (int k = 0; k < N_ENTITIES; k++)
                begin
                    same = (m <= ENTITY_LEN[k]);
                    for (int i = 0; i < m && same; i++)
                        if (seq[i] != ENTITY_TEXT[k][i])
                            same = 0;
                    if (same && m == ENTITY_LEN[k])
                        hit = k;
                    else if (same)
                        partial = 1;
                end
                if (hit >= 0)
                begin
                    r.data = ENTITY_CHAR[hit];
                    run.push_back(r);
                    held_len = 0;
                end
                else if (partial != 0 && m <= HOLD_DEPTH)
                begin
                    held_text[held_len] = b;
                    held_len = m;
                end
                else
                begin
                    // Mismatch: release the held bytes, then rescan the new one
                    for (int i = 0; i < held_len; i++)
                    begin
                        r.data = held_text[i];
                        run.push_back(r);
                    end
                    held_len = 0;
                    if (b == "&")
                    begin
                        held_text[0] = b;
                        held_len = 1;
                    end
                    else
                    begin
                        r.data = b;
                        run.push_back(r);
                    end
                end
            end
            // End of text flushes whatever is still held
            if (eot)
            begin
                for (int i = 0; i < held_len; i++)
                begin
                    r.data = held_text[i];
                    run.push_back(r);
                end
                held_len = 0;
            end
        end

        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
            run[run.size() - 1].done = eot;
        end
        foreach (run[i])
            expected_text.push_back(run[i]);
    endfunction

    // Watch both channels and the register port at each rising edge.
    // Check the output first: results of an item accepted at this edge can only
    // appear later, so queue order stays correct.
    always @(posedge clk)
    begin
        txt_res_t want;
        if (rst_n)
        begin
            if (txt_out_if.valid && txt_out_if.ready)
            begin
                if (expected_text.size() == 0)
                    flag_error($sformatf("unexpected byte %02h last %0b done %0b",
                        txt_out_if.byte_out, txt_out_if.last_of_run, txt_out_if.text_done));
                else
                begin
                    want = expected_text.pop_front();
                    if (txt_out_if.byte_out !== want.data
                        || txt_out_if.last_of_run !== want.last
                        || txt_out_if.text_done !== want.done)
                        flag_error($sformatf(
                            "expected byte %02h last %0b done %0b, got %02h last %0b done %0b",
                            want.data, want.last, want.done, txt_out_if.byte_out,
                            txt_out_if.last_of_run, txt_out_if.text_done));
                end
            end
            // A direction write drops any partial entity; other addresses do nothing
            if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION)
            begin
                cur_dir = dir_t'(pwdata[0]);
                held_len = 0;
            end
            if (txt_in_if.valid && txt_in_if.ready)
                convert_item(txt_in_if.byte_in, txt_in_if.end_of_text);
        end
    end

    // Receiver: cycle through steady, light random, periodic and heavy stall patterns
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0:    txt_out_if.ready <= 1'b1;
            2'd1:    txt_out_if.ready <= ($urandom_range(0, 2) != 0);
            2'd2:    txt_out_if.ready <= (stall_phase[2:0] < 3'd5);
            default: txt_out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Offer one item and hold it until accepted; pause between bursts.
    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(byte_t b, logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                txt_in_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        txt_in_if.valid       <= 1'b1;
        txt_in_if.byte_in     <= b;
        txt_in_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (!txt_in_if.ready);
        @(negedge clk);
    endtask

    // Send a string, marking end of text on its last byte if asked
    task automatic send_text(string s, bit eot_on_last);
        for (int i = 0; i < s.len(); i++)
            send_item(byte_t'(s[i]), eot_on_last && (i == s.len() - 1));
    endtask

    // Drop valid and wait until every owed byte has come, plus a settling margin
    // in case the block is still busy with an item that gives no result
    task automatic drain_output();
        txt_in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // Two-phase register write: setup, then access until pready
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
        drain_output();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the direction with random junk in the unused upper bits
    task automatic set_direction(dir_t d);
        logic [31:0] w;
        w = $urandom();
        w[0] = d;
        write_reg(ADDR_DIRECTION, w);
    endtask

    // Escape mode: zero and all-ones bytes, and each special character
    task automatic check_escape_extremes();
        set_direction(DIR_ESCAPE);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_text("&\"<>", 1'b1);
    endtask

    // Unescape mode: a full entity, a mismatch, a fresh '&' inside a mismatch,
    // and end of text with bytes still held
    task automatic check_unescape_cases();
        set_direction(DIR_UNESCAPE);
        send_text("&lt;", 1'b0);
        send_text("&ax", 1'b0);
        send_text("&&gt;", 1'b0);
        send_text("&qu", 1'b1);
        send_text("&", 1'b1);
    endtask

    // A write to an unused address must leave a partial entity intact
    task automatic check_spare_address();
        send_text("&l", 1'b0);
        write_reg(ADDR_SPARE, $urandom());
        send_text("t;", 1'b1);
    endtask

    // Rewriting the direction drops the partial entity
    task automatic check_direction_clears_hold();
        send_text("&am", 1'b0);
        set_direction(DIR_UNESCAPE);
        send_text("p;", 1'b1);
    endtask

    // Random bytes in escape mode, weighted toward the special characters
    task automatic run_random_escape(int count);
        byte_t b;
        set_direction(DIR_ESCAPE);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 2) == 0)
                b = ENTITY_CHAR[$urandom_range(0, N_ENTITIES - 1)];
            else
                b = byte_t'($urandom_range(0, 255));
            send_item(b, $urandom_range(0, 7) == 0);
        end
    endtask

    // Unescape mode: whole entities half the time, plus broken entities and noise.
    // Pause once midway until every owed byte has come.
    task automatic run_random_unescape(int count);
        byte_t frag [$];
        int    sent;
        int    k;
        int    cut;
        bit    eot;
        set_direction(DIR_UNESCAPE);
        sent = 0;
        while (sent < count)
        begin
            frag.delete();
            k = $urandom_range(0, N_ENTITIES - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    for (int i = 0; i < ENTITY_LEN[k]; i++)
                        frag.push_back(ENTITY_TEXT[k][i]);
                5, 6:
                begin
                    cut = $urandom_range(1, ENTITY_LEN[k] - 1);
                    for (int i = 0; i < cut; i++)
                        frag.push_back(ENTITY_TEXT[k][i]);
                    frag.push_back(byte_t'($urandom_range(0, 255)));
                end
                7:
                    frag.push_back(byte_t'($urandom_range(0, 255)));
                8:
                begin
                    frag.push_back("&");
                    frag.push_back(ENTITY_TEXT[$urandom_range(0, N_ENTITIES - 1)]
                        [$urandom_range(1, 3)]);
                end
                default:
                    frag.push_back(byte_t'($urandom_range(8'h20, 8'h7e)));
            endcase
            eot = ($urandom_range(0, 5) == 0);
            foreach (frag[i])
                send_item(frag[i], eot && (i == frag.size() - 1));
            if (sent < count / 2 && sent + frag.size() >= count / 2)
                drain_output();
            sent += frag.size();
        end
    endtask

    initial
    begin
        int guard;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        txt_in_if.valid       = 1'b0;
        txt_in_if.byte_in     = 8'h00;
        txt_in_if.end_of_text = 1'b0;
        txt_out_if.ready      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        check_escape_extremes();
        check_unescape_cases();
        check_spare_address();
        check_direction_clears_hold();
        run_random_escape(40);
        run_random_unescape(90);
        run_random_escape(30);
        run_random_unescape(90);

        // Stop sending, let the output drain, then give a margin for stray bytes
        txt_in_if.valid <= 1'b0;
        guard = 0;
        while (expected_text.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_text.size() != 0)
            flag_error($sformatf("%0d result bytes never came", expected_text.size()));
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule
